@@ rtl/lpxfr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpxfr_pkg: shared types and constants of the frame receiver
// Register indexes, status codes and the result record passed between stages.
// ----------------------------------------------------------------------------
package lpxfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 8;

  // Largest length byte that can ever be accepted
  localparam logic [ByteW-1:0] LenCap = 8'd253;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MIN_LENGTH = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH = 8'd1;

  // Configuration reset values
  localparam logic [ByteW-1:0] MinLengthRst = 8'd2;
  localparam logic [ByteW-1:0] MaxLengthRst = 8'd253;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_GOOD    = 2'd1,
    ST_CSUM_ER = 2'd2,
    ST_LEN_ER  = 2'd3
  } status_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic [ByteW-1:0] byte_index;
    logic             frame_end;
    status_t          frame_status;
    logic [ByteW-1:0] source_id;
    logic [ByteW-1:0] dest_id;
    logic [ByteW-1:0] frame_length;
  } result_t;

  typedef struct packed {
    logic [ByteW-1:0] min_length;
    logic [ByteW-1:0] max_length;
  } cfg_t;

endpackage

@@ rtl/lpxfr_if.sv @@
// ----------------------------------------------------------------------------
// lpxfr_if: valid/ready channels of the frame receiver
// One channel for received bytes and one for per-byte results.
// ----------------------------------------------------------------------------
interface lpxfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpxfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [7:0] byte_index;
  logic       frame_end;
  logic [1:0] frame_status;
  logic [7:0] source_id;
  logic [7:0] dest_id;
  logic [7:0] frame_length;

  modport source (
    output valid, output byte_value, output byte_index, output frame_end,
    output frame_status, output source_id, output dest_id, output frame_length,
    input ready
  );
  modport sink (
    input valid, input byte_value, input byte_index, input frame_end,
    input frame_status, input source_id, input dest_id, input frame_length,
    output ready
  );
endinterface

@@ rtl/lpxfr_parser.sv @@
// ----------------------------------------------------------------------------
// lpxfr_parser: frame position tracking and per-byte result
// Holds header fields and the running XOR; updates them once per fired byte.
// ----------------------------------------------------------------------------
module lpxfr_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [lpxfr_pkg::ByteW-1:0] rx_byte,
  input  lpxfr_pkg::cfg_t             cfg,
  output lpxfr_pkg::result_t          res
);
  import lpxfr_pkg::*;

  logic [ByteW-1:0] byte_position, byte_position_next;
  logic [ByteW-1:0] held_source, held_source_next;
  logic [ByteW-1:0] held_length, held_length_next;
  logic [ByteW-1:0] held_dest, held_dest_next;
  logic [ByteW-1:0] running_xor, running_xor_next;

  logic at_src, at_len, at_dst;
  logic len_bad, csum_pos;
  logic [ByteW:0] len_plus_one;

  assign at_src = (byte_position == 8'd0);
  assign at_len = (byte_position == 8'd1);
  assign at_dst = (byte_position == 8'd2);

  assign len_bad = at_len && ((rx_byte == 8'd0) || (rx_byte > LenCap) ||
                              (rx_byte < cfg.min_length) || (rx_byte > cfg.max_length));

  assign len_plus_one = {1'b0, held_length} + 9'd1;
  assign csum_pos     = (byte_position >= 8'd2) && ({1'b0, byte_position} == len_plus_one);

  always_comb begin
    res.byte_value   = rx_byte;
    res.byte_index   = byte_position;
    res.source_id    = at_src ? rx_byte : held_source;
    res.frame_length = at_len ? rx_byte : held_length;
    res.dest_id      = at_dst ? rx_byte : held_dest;
    res.frame_end    = 1'b0;
    res.frame_status = ST_BUSY;
    if (len_bad) begin
      res.frame_end    = 1'b1;
      res.frame_status = ST_LEN_ER;
    end else if (csum_pos) begin
      res.frame_end    = 1'b1;
      res.frame_status = (running_xor == rx_byte) ? ST_GOOD : ST_CSUM_ER;
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    held_source_next   = held_source;
    held_length_next   = held_length;
    held_dest_next     = held_dest;
    running_xor_next   = running_xor;
    if (fire) begin
      if (res.frame_end) begin
        // restart for the next frame
        byte_position_next = '0;
        held_source_next   = '0;
        held_length_next   = '0;
        held_dest_next     = '0;
        running_xor_next   = '0;
      end else begin
        byte_position_next = byte_position + 8'd1;
        held_source_next   = res.source_id;
        held_length_next   = res.frame_length;
        held_dest_next     = res.dest_id;
        running_xor_next   = running_xor ^ rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      held_source   <= '0;
      held_length   <= '0;
      held_dest     <= '0;
      running_xor   <= '0;
    end else begin
      byte_position <= byte_position_next;
      held_source   <= held_source_next;
      held_length   <= held_length_next;
      held_dest     <= held_dest_next;
      running_xor   <= running_xor_next;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LenCap + 8'd1)
    else $error("frame position beyond checksum limit");

  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    fire && res.frame_end |=> byte_position == 8'd0 && running_xor == 8'd0)
    else $error("frame state not cleared after frame end");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    fire && !res.frame_end |=> byte_position == $past(byte_position) + 8'd1)
    else $error("frame position did not advance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(byte_position) && $stable(running_xor))
    else $error("frame state moved without a byte");

endmodule

@@ rtl/lpxfr_out_buf.sv @@
// ----------------------------------------------------------------------------
// lpxfr_out_buf: result register
// Holds one result until the consumer takes it; reloads in the same cycle.
// ----------------------------------------------------------------------------
module lpxfr_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  lpxfr_pkg::result_t res,
  output logic               free,
  lpxfr_out_if.source        frame
);
  import lpxfr_pkg::*;

  logic    valid;
  result_t data;

  assign free = !valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      data <= res;
    end
  end

  assign frame.valid        = valid;
  assign frame.byte_value   = data.byte_value;
  assign frame.byte_index   = data.byte_index;
  assign frame.frame_end    = data.frame_end;
  assign frame.frame_status = data.frame_status;
  assign frame.source_id    = data.source_id;
  assign frame.dest_id      = data.dest_id;
  assign frame.frame_length = data.frame_length;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result loaded while previous one is still waiting");

endmodule

@@ rtl/length_prefixed_xor_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_xor_frame_receiver: byte stream frame checker
// Splits a byte stream into length-prefixed frames and checks the XOR sum.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the rx channel (valid/ready, one byte per transaction).
//   Frames are: source, length, destination, data, checksum; the length
//   counts all bytes after itself, checksum included. Every input byte
//   yields exactly one transaction on the frame channel carrying the byte,
//   its index, the captured header fields and a status: in progress, good,
//   checksum error, or length error. A length byte of zero, above 253, or
//   outside [min_length, max_length] ends the frame on that byte.
//   Configuration: cfg_we with cfg_index 0 writes min_length, index 1 writes
//   max_length; other indexes are ignored. Write only while the block is idle.
//   Path: an accepted rx byte passes the input register, then the result
//   register, before frame.valid rises. Throughput: one byte per cycle
//   while frame.ready stays high; the parser updates the frame state once
//   per byte.
//   Reset: the pipeline empties, the frame state returns to the source
//   position, min_length = 2 and max_length = 253.
//   Stall: while frame.ready is low the result register holds; the input
//   register then fills and rx.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module length_prefixed_xor_frame_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lpxfr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lpxfr_pkg::ByteW-1:0]   cfg_data,
  lpxfr_in_if.sink                      rx,
  lpxfr_out_if.source                   frame
);
  import lpxfr_pkg::*;

  cfg_t             cfg;
  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             buf_free;
  logic             advance;
  result_t          res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_length <= MinLengthRst;
      cfg.max_length <= MaxLengthRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_LENGTH: cfg.min_length <= cfg_data;
        REG_MAX_LENGTH: cfg.max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the input register into the result register when there is room
  assign advance  = in_valid && buf_free;
  assign rx.ready = !in_valid || buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  // Capture the byte on each accepted transaction
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  lpxfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  lpxfr_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .load  (advance),
    .res   (res),
    .free  (buf_free),
    .frame (frame)
  );

endmodule
